// ----- hdl/rbad_pkg.sv -----
`default_nettype none

package rbad_pkg;

	// Width of the decimal length accumulator and of the payload byte counter.
	localparam int unsigned LEN_BITS = 32;

	localparam int unsigned PHASE_BITS = 3;
	localparam int unsigned SKIP_BITS  = 2;

	typedef logic [LEN_BITS-1:0]   len_t;
	typedef logic [PHASE_BITS-1:0] phase_t;
	typedef logic [SKIP_BITS-1:0]  skip_t;

	// Parser phases. The eighth code is unused and behaves as the initial phase.
	localparam phase_t PH_INIT      = 3'd0;
	localparam phase_t PH_ARRAY_LEN = 3'd1;
	localparam phase_t PH_OP_LEN    = 3'd2;
	localparam phase_t PH_OP_STR    = 3'd3;
	localparam phase_t PH_PAR_LEN   = 3'd4;
	localparam phase_t PH_PAR_STR   = 3'd5;
	localparam phase_t PH_BRANCH    = 3'd6;

	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	// Separator bytes skipped after a length: CR LF and the dollar sign.
	localparam skip_t SKIP_CR_LF_DOLLAR = 2'd3;
	localparam skip_t SKIP_AFTER_LEN    = SKIP_CR_LF_DOLLAR - 2'd1;
	localparam skip_t SKIP_LF           = 2'd1;

	typedef struct packed {
		logic [7:0] payload_byte;
		logic       has_byte;
		logic       is_operator;
		logic       string_end;
		logic       request_done;
		logic       format_error;
	} result_t;

endpackage

`default_nettype wire

// ----- hdl/rbad_if.sv -----
`default_nettype none

interface rbad_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink   (input valid, input in_byte, output ready);
endinterface

interface rbad_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] payload_byte;
	logic       has_byte;
	logic       is_operator;
	logic       string_end;
	logic       request_done;
	logic       format_error;

	modport source (output valid, output payload_byte, output has_byte, output is_operator,
		output string_end, output request_done, output format_error, input ready);
	modport sink   (input valid, input payload_byte, input has_byte, input is_operator,
		input string_end, input request_done, input format_error, output ready);
endinterface

`default_nettype wire

// ----- hdl/resp_bulk_array_deframer.sv -----
`default_nettype none

// Channel | Direction | Payload                                   | Meaning
// req     | in        | in_byte                                   | one request byte
// rsp     | out       | payload_byte, has_byte, is_operator,      | string byte or
//         |           | string_end, request_done, format_error    | framing event
//
// One request byte is taken per clock while the input does not stall. A byte
// passes an input register and then the parser logic into a result register,
// from which the sink takes the result.
// Bytes that report nothing (digits, separators, markers) drain from the input
// register without touching the result register.
// Reset puts the parser in its initial phase with empty length and counters.
// The input stalls only when the byte in the input register needs the result
// register while that register still holds a result the sink has not taken.
module resp_bulk_array_deframer (
	input  wire logic          clk,
	input  wire logic          arst_n,
	rbad_byte_if.sink          req,
	rbad_result_if.source      rsp
);

	// Input register stage.
	logic       valid_s1;
	logic [7:0] byte_s1;

	// Parser state.
	rbad_pkg::phase_t phase_q;
	rbad_pkg::skip_t  skip_q;
	rbad_pkg::len_t   length_q;
	logic             stopped_q;
	rbad_pkg::len_t   seen_q;

	// Result register.
	logic              out_valid_q;
	rbad_pkg::result_t result_q;

	// Next-state values computed from the byte in the input register.
	rbad_pkg::phase_t  phase_d;
	rbad_pkg::skip_t   skip_d;
	rbad_pkg::len_t    length_d;
	logic              stopped_d;
	rbad_pkg::len_t    seen_d;
	rbad_pkg::result_t result_d;
	logic              produce;

	logic           is_digit;
	rbad_pkg::len_t digit_val;
	rbad_pkg::len_t length_x10;
	logic           out_free;
	logic           advance_s1;

	assign is_digit   = (byte_s1 >= rbad_pkg::CH_ZERO) && (byte_s1 <= rbad_pkg::CH_NINE);
	assign digit_val  = rbad_pkg::len_t'(byte_s1 - rbad_pkg::CH_ZERO);
	// Times ten as a sum of two shifts; the top bits wrap away.
	assign length_x10 = (length_q << 3) + (length_q << 1);

	always_comb begin
		phase_d   = phase_q;
		skip_d    = skip_q;
		length_d  = length_q;
		stopped_d = stopped_q;
		seen_d    = seen_q;
		result_d  = '0;
		produce   = 1'b0;

		if (phase_q == rbad_pkg::PH_INIT || phase_q > rbad_pkg::PH_BRANCH) begin
			// Only a star may open a request; anything else is reported and ignored.
			phase_d   = rbad_pkg::PH_INIT;
			skip_d    = '0;
			length_d  = '0;
			stopped_d = 1'b0;
			seen_d    = '0;
			if (byte_s1 == rbad_pkg::CH_STAR) begin
				phase_d = rbad_pkg::PH_ARRAY_LEN;
			end else begin
				produce               = 1'b1;
				result_d.format_error = 1'b1;
			end
		end else if (byte_s1 == rbad_pkg::CH_NUL) begin
			// NUL ends the request from anywhere, even inside a payload.
			phase_d               = rbad_pkg::PH_INIT;
			skip_d                = '0;
			length_d              = '0;
			stopped_d             = 1'b0;
			seen_d                = '0;
			produce               = 1'b1;
			result_d.request_done = 1'b1;
		end else if (skip_q != '0) begin
			// Separators are counted off, not checked.
			skip_d = skip_q - 2'd1;
		end else begin
			unique case (phase_q)
				rbad_pkg::PH_ARRAY_LEN, rbad_pkg::PH_OP_LEN, rbad_pkg::PH_PAR_LEN: begin
					if (byte_s1 == rbad_pkg::CH_CR) begin
						seen_d = '0;
						if (phase_q == rbad_pkg::PH_ARRAY_LEN) begin
							// The array count is dropped here.
							phase_d   = rbad_pkg::PH_OP_LEN;
							skip_d    = rbad_pkg::SKIP_AFTER_LEN;
							length_d  = '0;
							stopped_d = 1'b0;
						end else begin
							phase_d = (phase_q == rbad_pkg::PH_OP_LEN) ?
								rbad_pkg::PH_OP_STR : rbad_pkg::PH_PAR_STR;
							skip_d  = rbad_pkg::SKIP_LF;
						end
					end else if (!stopped_q && is_digit) begin
						length_d = length_x10 + digit_val;
					end else begin
						// The first non-digit freezes the length.
						stopped_d = 1'b1;
					end
				end
				rbad_pkg::PH_OP_STR, rbad_pkg::PH_PAR_STR: begin
					produce              = 1'b1;
					result_d.is_operator = (phase_q == rbad_pkg::PH_OP_STR);
					if (seen_q < length_q) begin
						result_d.payload_byte = byte_s1;
						result_d.has_byte     = 1'b1;
						seen_d                = seen_q + rbad_pkg::len_t'(1);
					end else begin
						// The byte after the last payload byte marks the end.
						result_d.string_end = 1'b1;
						seen_d              = '0;
						if (phase_q == rbad_pkg::PH_OP_STR) begin
							phase_d   = rbad_pkg::PH_PAR_LEN;
							skip_d    = rbad_pkg::SKIP_AFTER_LEN;
							length_d  = '0;
							stopped_d = 1'b0;
						end else begin
							phase_d = rbad_pkg::PH_BRANCH;
							skip_d  = rbad_pkg::SKIP_LF;
						end
					end
				end
				default: begin
					// After a parameter: another parameter, a new array, or a stray byte.
					if (byte_s1 == rbad_pkg::CH_DOLLAR) begin
						phase_d   = rbad_pkg::PH_PAR_LEN;
						length_d  = '0;
						stopped_d = 1'b0;
					end else if (byte_s1 == rbad_pkg::CH_STAR) begin
						phase_d   = rbad_pkg::PH_ARRAY_LEN;
						length_d  = '0;
						stopped_d = 1'b0;
					end else begin
						phase_d               = rbad_pkg::PH_INIT;
						skip_d                = '0;
						length_d              = '0;
						stopped_d             = 1'b0;
						seen_d                = '0;
						produce               = 1'b1;
						result_d.request_done = 1'b1;
						result_d.format_error = 1'b1;
					end
				end
			endcase
		end
	end

	// The input register empties when its byte needs no result slot or the slot
	// is free this cycle.
	assign out_free   = !out_valid_q || rsp.ready;
	assign advance_s1 = valid_s1 && (!produce || out_free);
	assign req.ready  = !valid_s1 || advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			phase_q     <= rbad_pkg::PH_INIT;
			skip_q      <= '0;
			length_q    <= '0;
			stopped_q   <= 1'b0;
			seen_q      <= '0;
		end else begin
			if (req.ready) begin
				valid_s1 <= req.valid;
			end
			if (advance_s1) begin
				phase_q   <= phase_d;
				skip_q    <= skip_d;
				length_q  <= length_d;
				stopped_q <= stopped_d;
				seen_q    <= seen_d;
			end
			if (advance_s1 && produce) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			byte_s1 <= req.in_byte;
		end
		if (advance_s1 && produce) begin
			result_q <= result_d;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.payload_byte = result_q.payload_byte;
	assign rsp.has_byte     = result_q.has_byte;
	assign rsp.is_operator  = result_q.is_operator;
	assign rsp.string_end   = result_q.string_end;
	assign rsp.request_done = result_q.request_done;
	assign rsp.format_error = result_q.format_error;

endmodule

`default_nettype wire
